// ===== rtl/adsr_pkg.sv =====
`default_nettype none

package adsr_pkg;

  // Gain is unsigned Q1.16: 17 bits, 65536 is unity.
  localparam int GAIN_BITS = 17;
  localparam int FRAC_BITS = 16;
  localparam logic [GAIN_BITS-1:0] UNITY = 17'h1_0000;

  localparam int DEF_SAMPLE_BITS = 16;
  localparam int DEF_COUNT_BITS  = 24;

  // APB register map, byte address = 4 * index
  localparam int ADDR_BITS = 4;
  localparam int REG_IDX_BITS = 2;
  localparam logic [REG_IDX_BITS-1:0] REG_ATTACK  = 2'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_DECAY   = 2'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_RELEASE = 2'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_SUSTAIN = 2'd3;

  // Controller -> datapath commands
  typedef struct packed {
    logic accept;    // capture input beat, update note position
    logic select;    // pick phase, ramp operands
    logic mul;       // form dividend, load divider
    logic div_step;  // one restoring-division step
    logic gain;      // final gain from ramp base and quotient
    logic out_load;  // scale sample, load output register
  } adsr_cmd_t;

  // Datapath -> controller status
  typedef struct packed {
    logic div_last;
  } adsr_sts_t;

endpackage

`default_nettype wire

// ===== rtl/adsr_ctrl.sv =====
`default_nettype none

module adsr_ctrl
  import adsr_pkg::*;
(
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire logic      in_valid_i,
  output logic           in_ready_o,
  output logic           out_valid_o,
  input  wire logic      out_ready_i,
  output adsr_cmd_t      cmd_o,
  input  wire adsr_sts_t sts_i
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SEL  = 3'd1;
  localparam logic [2:0] S_MUL  = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_GAIN = 3'd4;
  localparam logic [2:0] S_OUT  = 3'd5;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;
  logic       out_free;

  assign out_free    = !out_valid_q || out_ready_i;
  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = out_valid_q;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          state_d = S_SEL;
        end
      end
      S_SEL: begin
        cmd_o.select = 1'b1;
        state_d = S_MUL;
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) begin
          state_d = S_GAIN;
        end
      end
      S_GAIN: begin
        cmd_o.gain = 1'b1;
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          cmd_o.out_load = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // a result waiting on a stalled receiver is never overwritten
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> out_valid_q)
    else $error("result beat dropped under stall");

  // an accepted beat always enters phase selection next
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> (state_q == S_SEL))
    else $error("accepted beat did not start processing");

  // finishing a result with the output register still full is a slip
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_OUT && out_valid_q && !out_ready_i) |=> (state_q == S_OUT))
    else $error("left output state while output register full");

endmodule

`default_nettype wire

// ===== rtl/adsr_dp.sv =====
`default_nettype none

module adsr_dp
  import adsr_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire adsr_cmd_t                     cmd_i,
  output adsr_sts_t                          sts_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  wire logic                          note_start_i,
  input  wire logic [COUNT_BITS-1:0]         note_length_i,
  input  wire logic [COUNT_BITS-1:0]         att_len_i,
  input  wire logic [COUNT_BITS-1:0]         dec_len_i,
  input  wire logic [COUNT_BITS-1:0]         rel_len_i,
  input  wire logic [GAIN_BITS-1:0]          sus_lvl_i,
  output logic signed [SAMPLE_BITS-1:0]      sample_out_o,
  output logic [GAIN_BITS-1:0]               gain_o,
  output logic                               note_last_o
);

  localparam int NUM_BITS  = GAIN_BITS + COUNT_BITS;
  localparam int PROD_BITS = SAMPLE_BITS + GAIN_BITS + 1;
  localparam int STEP_BITS = $clog2(GAIN_BITS);
  localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(GAIN_BITS - 1);
  localparam logic [COUNT_BITS-1:0] ONE = COUNT_BITS'(1);

  // note position state
  logic [COUNT_BITS-1:0] position_q, position_d;
  logic [COUNT_BITS-1:0] length_q, length_d;

  // captured beat
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic [COUNT_BITS-1:0]         p_q;
  logic [COUNT_BITS-1:0]         p_new;

  // ramp operands
  logic [GAIN_BITS-1:0]  base_q, base_d;
  logic [GAIN_BITS-1:0]  delta_q, delta_d;
  logic [COUNT_BITS-1:0] idx_q, idx_d;
  logic [COUNT_BITS-1:0] dvs_q, dvs_d;
  logic                  up_q, up_d;
  logic                  last_q, last_d;

  // divider
  logic [COUNT_BITS-1:0] rem_q, rem_d;
  logic [GAIN_BITS-1:0]  low_q, low_d;
  logic [STEP_BITS-1:0]  step_q;
  logic [NUM_BITS-1:0]   num;
  logic [COUNT_BITS:0]   trial;
  logic                  fits;

  logic [GAIN_BITS-1:0]  gain_q;
  logic signed [PROD_BITS-1:0] prod;

  // output register
  logic signed [SAMPLE_BITS-1:0] sample_out_q;
  logic [GAIN_BITS-1:0]          gain_out_q;
  logic                          last_out_q;

  // phase selection
  logic [GAIN_BITS-1:0]  sus;
  logic [COUNT_BITS:0]   pr_sum;
  logic [COUNT_BITS:0]   p_inc;
  logic [COUNT_BITS:0]   rel_pos;
  logic [COUNT_BITS-1:0] dec_pos;
  logic                  off_note, in_rel, in_att, in_dec;

  assign p_new = note_start_i ? '0 : position_q;

  always_comb begin
    position_d = position_q;
    length_d   = length_q;
    if (cmd_i.accept) begin
      length_d   = note_start_i ? note_length_i : length_q;
      position_d = (&p_new) ? p_new : p_new + ONE;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      position_q <= '0;
      length_q   <= '0;
    end else begin
      position_q <= position_d;
      length_q   <= length_d;
    end
  end

  assign sus     = (sus_lvl_i > UNITY) ? UNITY : sus_lvl_i;
  assign pr_sum  = {1'b0, p_q} + {1'b0, rel_len_i};
  assign p_inc   = {1'b0, p_q} + {1'b0, ONE};
  assign rel_pos = pr_sum - {1'b0, length_q};
  assign dec_pos = p_q - att_len_i;

  assign off_note = (p_q >= length_q);
  assign in_rel   = (pr_sum >= {1'b0, length_q});
  assign in_att   = (p_q < att_len_i);
  assign in_dec   = (dec_pos < dec_len_i);

  // Flat segments use a zero delta over a divisor of one, so the divider
  // always runs and returns zero.
  always_comb begin
    base_d  = '0;
    delta_d = '0;
    idx_d   = '0;
    dvs_d   = ONE;
    up_d    = 1'b1;
    last_d  = !off_note && (p_inc == {1'b0, length_q});
    priority if (off_note) begin
      base_d = '0;
    end else if (in_rel) begin
      if (rel_len_i != ONE) begin
        base_d  = sus;
        delta_d = sus;
        idx_d   = rel_pos[COUNT_BITS-1:0];
        dvs_d   = rel_len_i - ONE;
        up_d    = 1'b0;
      end
    end else if (in_att) begin
      if (att_len_i == ONE) begin
        base_d = UNITY;
      end else begin
        delta_d = UNITY;
        idx_d   = p_q;
        dvs_d   = att_len_i - ONE;
      end
    end else if (in_dec) begin
      if (dec_len_i == ONE) begin
        base_d = sus;
      end else begin
        base_d  = UNITY;
        delta_d = UNITY - sus;
        idx_d   = dec_pos;
        dvs_d   = dec_len_i - ONE;
        up_d    = 1'b0;
      end
    end else begin
      base_d = sus;
    end
  end

  // Dividend is delta * idx + dvs/2; quotient fits in GAIN_BITS since idx <= dvs,
  // so the top COUNT_BITS of the dividend are already below the divisor.
  assign num   = NUM_BITS'(delta_q) * NUM_BITS'(idx_q) + NUM_BITS'(dvs_q >> 1);
  assign trial = {rem_q, low_q[GAIN_BITS-1]};
  assign fits  = (trial >= {1'b0, dvs_q});

  always_comb begin
    rem_d = rem_q;
    low_d = low_q;
    if (cmd_i.mul) begin
      rem_d = num[NUM_BITS-1:GAIN_BITS];
      low_d = num[GAIN_BITS-1:0];
    end else if (cmd_i.div_step) begin
      rem_d = fits ? COUNT_BITS'(trial - {1'b0, dvs_q}) : trial[COUNT_BITS-1:0];
      low_d = {low_q[GAIN_BITS-2:0], fits};
    end
  end

  assign sts_o.div_last = (step_q == LAST_STEP);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= '0;
    end else if (cmd_i.mul) begin
      step_q <= '0;
    end else if (cmd_i.div_step) begin
      step_q <= step_q + STEP_BITS'(1);
    end
  end

  assign prod = $signed(sample_q) * $signed({1'b0, gain_q});

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      sample_q <= sample_in_i;
      p_q      <= p_new;
    end
    if (cmd_i.select) begin
      base_q  <= base_d;
      delta_q <= delta_d;
      idx_q   <= idx_d;
      dvs_q   <= dvs_d;
      up_q    <= up_d;
      last_q  <= last_d;
    end
    rem_q <= rem_d;
    low_q <= low_d;
    if (cmd_i.gain) begin
      gain_q <= up_q ? base_q + low_q : base_q - low_q;
    end
    if (cmd_i.out_load) begin
      sample_out_q <= prod[FRAC_BITS +: SAMPLE_BITS];
      gain_out_q   <= gain_q;
      last_out_q   <= last_q;
    end
  end

  assign sample_out_o = sample_out_q;
  assign gain_o       = gain_out_q;
  assign note_last_o  = last_out_q;

  // restoring division keeps the partial remainder below the divisor
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.div_step |=> (rem_q < dvs_q))
    else $error("divider remainder out of range");

  // envelope never exceeds unity
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.gain |=> (gain_q <= UNITY))
    else $error("gain above unity");

endmodule

`default_nettype wire

// ===== rtl/adsr_envelope_applier.sv =====
// Linear ADSR envelope applier.
// Input channel (in_valid_i/in_ready_o): one beat per audio sample carrying
// sample_in_i, note_start_i and note_length_i. note_start_i restarts the note
// position and latches note_length_i. Output channel (out_valid_o/out_ready_i):
// one beat per input beat with the scaled sample, the applied Q1.16 gain and a
// flag on the last sample of the note.
// Processing: an input beat passes phase selection, dividend formation, the
// 17-step restoring divider that interpolates the ramp point and gain
// formation before it is loaded into the output register. A new beat is taken
// in the cycle after the previous result was loaded, so beats do not overlap.
// The output register holds a finished result while the receiver stalls; the
// next beat is accepted and processed meanwhile and waits in the final stage
// until the output register frees up.
// The user must write ramp lengths, sustain level over APB only while idle;
// the block does not enforce it. Reset clears note position and length (all
// samples outside a note, gain 0), zeroes ramp lengths, sets sustain to unity.
`default_nettype none

module adsr_envelope_applier
  import adsr_pkg::*;
#(
  parameter int SAMPLE_BITS = DEF_SAMPLE_BITS,
  parameter int COUNT_BITS  = DEF_COUNT_BITS
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          psel,
  input  wire logic                          penable,
  input  wire logic                          pwrite,
  input  wire logic [ADDR_BITS-1:0]          paddr,
  input  wire logic [31:0]                   pwdata,
  output logic [31:0]                        prdata,
  output logic                               pready,
  input  wire logic                          in_valid_i,
  output logic                               in_ready_o,
  input  wire logic signed [SAMPLE_BITS-1:0] sample_in_i,
  input  wire logic                          note_start_i,
  input  wire logic [COUNT_BITS-1:0]         note_length_i,
  output logic                               out_valid_o,
  input  wire logic                          out_ready_i,
  output logic signed [SAMPLE_BITS-1:0]      sample_out_o,
  output logic [GAIN_BITS-1:0]               gain_o,
  output logic                               note_last_o
);

  logic [COUNT_BITS-1:0] attack_length_q;
  logic [COUNT_BITS-1:0] decay_length_q;
  logic [COUNT_BITS-1:0] release_length_q;
  logic [GAIN_BITS-1:0]  sustain_level_q;
  logic [REG_IDX_BITS-1:0] reg_idx;
  logic                  wr_en;

  adsr_cmd_t cmd;
  adsr_sts_t sts;

  assign pready  = 1'b1;
  assign wr_en   = psel && penable && pwrite;
  assign reg_idx = paddr[ADDR_BITS-1:2];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      attack_length_q  <= '0;
      decay_length_q   <= '0;
      release_length_q <= '0;
      sustain_level_q  <= UNITY;
    end else if (wr_en) begin
      unique case (reg_idx)
        REG_ATTACK:  attack_length_q  <= pwdata[COUNT_BITS-1:0];
        REG_DECAY:   decay_length_q   <= pwdata[COUNT_BITS-1:0];
        REG_RELEASE: release_length_q <= pwdata[COUNT_BITS-1:0];
        REG_SUSTAIN: sustain_level_q  <= pwdata[GAIN_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ATTACK:  prdata = 32'(attack_length_q);
      REG_DECAY:   prdata = 32'(decay_length_q);
      REG_RELEASE: prdata = 32'(release_length_q);
      REG_SUSTAIN: prdata = 32'(sustain_level_q);
      default:     prdata = '0;
    endcase
  end

  adsr_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  adsr_dp #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COUNT_BITS  (COUNT_BITS)
  ) u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .sts_o         (sts),
    .sample_in_i   (sample_in_i),
    .note_start_i  (note_start_i),
    .note_length_i (note_length_i),
    .att_len_i     (attack_length_q),
    .dec_len_i     (decay_length_q),
    .rel_len_i     (release_length_q),
    .sus_lvl_i     (sustain_level_q),
    .sample_out_o  (sample_out_o),
    .gain_o        (gain_o),
    .note_last_o   (note_last_o)
  );

endmodule

`default_nettype wire
